### rtl/vlan_tag_insert_unit_defines.svh
// ----------------------------------------------------------------------------
// vlan_tag_insert_unit_defines.svh
// Assertion macros for the VLAN tag insertion RTL (used by vti_back).
// ----------------------------------------------------------------------------
`ifndef VLAN_TAG_INSERT_UNIT_DEFINES_SVH
`define VLAN_TAG_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define VTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vlan_tag_insert_unit: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define VTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vlan_tag_insert_unit: next-cycle check failed");

`endif

### rtl/vti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vti_pkg
// Types and constants for the VLAN tag insertion unit.
// ----------------------------------------------------------------------------
package vti_pkg;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int TCI_W      = 16;

    // Frame header positions
    localparam int            POS_W        = 4;
    localparam logic [POS_W-1:0] POS_TYPE_HI = 4'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LO = 4'd13;
    localparam logic [POS_W-1:0] POS_BODY    = 4'd14;

    // Tag protocol identifiers
    localparam logic [15:0] TPID_VLAN = 16'h8100;
    localparam logic [15:0] TPID_QINQ = 16'h88A8;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Steps of the tag burst
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_TPID_HI = 3'd0;
    localparam logic [STEP_W-1:0] STEP_TPID_LO = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TCI_HI  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_TCI_LO  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_HELD    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_TYPE_LO = 3'd5;

    typedef enum logic {
        OP_PASS = 1'b0,
        OP_TAG  = 1'b1
    } t_op;

    // One queued operation for the back end
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
        logic [7:0] held;
        logic       qinq;
    } t_q_entry;

endpackage

### rtl/vti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vti_front
// Tracks the byte position in a frame, holds byte 12 and classifies bytes.
// ----------------------------------------------------------------------------
module vti_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_frame_byte,
    input  logic              i_frame_end,
    output logic              o_in_stall,
    input  logic              i_q_full,
    output logic              o_push,
    output vti_pkg::t_q_entry o_push_entry
);
    import vti_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       r_held;
    logic [7:0]       n_held;
    logic             accept;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        n_pos             = r_pos;
        n_held            = r_held;
        o_push            = 1'b0;
        o_push_entry.op   = OP_PASS;
        o_push_entry.data = i_frame_byte;
        o_push_entry.last = i_frame_end;
        o_push_entry.held = r_held;
        o_push_entry.qinq = (r_held == TPID_VLAN[15:8]) && (i_frame_byte == TPID_VLAN[7:0]);
        if (accept) begin
            if (r_pos < POS_TYPE_HI) begin
                o_push = 1'b1;
                n_pos  = i_frame_end ? '0 : r_pos + 1'b1;
            end else if (r_pos == POS_TYPE_HI) begin
                if (i_frame_end) begin
                    o_push = 1'b1;
                    n_pos  = '0;
                end else begin
                    // hold byte 12 until the type field is complete
                    n_held = i_frame_byte;
                    n_pos  = POS_TYPE_LO;
                end
            end else if (r_pos == POS_TYPE_LO) begin
                o_push          = 1'b1;
                o_push_entry.op = OP_TAG;
                n_pos           = i_frame_end ? '0 : POS_BODY;
            end else begin
                o_push = 1'b1;
                n_pos  = i_frame_end ? '0 : POS_BODY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

### rtl/vti_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vti_fifo
// Short queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module vti_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vti_pkg::t_q_entry i_push_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output vti_pkg::t_q_entry o_head
);
    import vti_pkg::*;

    t_q_entry        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

### rtl/vti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vti_back
// Emits queued operations as output bytes; expands a tag into six bytes.
// ----------------------------------------------------------------------------
`include "vlan_tag_insert_unit_defines.svh"

module vti_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [vti_pkg::TCI_W-1:0]  i_tci,
    input  logic                       i_q_valid,
    input  vti_pkg::t_q_entry          i_q_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    output logic [7:0]                 o_out_byte,
    output logic                       o_out_end,
    output logic                       o_run_last,
    input  logic                       i_out_stall
);
    import vti_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_end;
    logic              r_run_last;
    logic              out_free;
    logic              load;
    logic [15:0]       tpid;
    logic [7:0]        n_byte;
    logic              n_end;
    logic              n_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = out_free && i_q_valid;
    assign tpid     = i_q_head.qinq ? TPID_QINQ : TPID_VLAN;
    assign o_pop    = load && ((i_q_head.op == OP_PASS) || (r_step == STEP_TYPE_LO));

    always_comb begin
        n_byte = i_q_head.data;
        n_end  = i_q_head.last;
        n_last = 1'b1;
        if (i_q_head.op == OP_TAG) begin
            n_end  = 1'b0;
            n_last = 1'b0;
            case (r_step)
                STEP_TPID_HI: n_byte = tpid[15:8];
                STEP_TPID_LO: n_byte = tpid[7:0];
                STEP_TCI_HI:  n_byte = i_tci[15:8];
                STEP_TCI_LO:  n_byte = i_tci[7:0];
                STEP_HELD:    n_byte = i_q_head.held;
                default: begin
                    n_byte = i_q_head.data;
                    n_end  = i_q_head.last;
                    n_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_TPID_HI;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= i_q_valid;
            end
            if (load && (i_q_head.op == OP_TAG)) begin
                r_step <= (r_step == STEP_TYPE_LO) ? STEP_TPID_HI : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= n_byte;
            r_out_end  <= n_end;
            r_run_last <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_end   = r_out_end;
    assign o_run_last  = r_run_last;

    // a burst in progress keeps its tag operation at the queue head
    `VTI_ASSERT_NOW(a_step_on_tag, i_clk, i_rst_n, r_step != STEP_TPID_HI, i_q_valid && (i_q_head.op == OP_TAG))
    // frame end only on the last byte of a transaction's run
    `VTI_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, r_out_valid && !r_run_last, !r_out_end)
    // the tag burst runs without gaps
    `VTI_ASSERT_NEXT(a_burst_no_gap, i_clk, i_rst_n, r_out_valid && !i_out_stall && !r_run_last, r_out_valid)

endmodule

### rtl/vlan_tag_insert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlan_tag_insert_unit
// IEEE 802.1Q VLAN tag insertion on a byte stream, with an APB TCI register.
// ----------------------------------------------------------------------------
// Frame bytes enter and leave one per cycle when neither side stalls.
// Byte 12 (the high byte of the type field) is held back and produces no
// output transaction; when byte 13 arrives the unit emits six bytes: the TPID
// (0x88A8 if the original type was 0x8100, else 0x8100), the TCI from the
// tag_control register, the held byte 12 and byte 13. Those six bytes leave
// one at a time through the single output register, so a tagged frame is
// four bytes longer; the input stalls whenever the four-entry operation
// queue is full. A frame ending before byte 12 passes unchanged, and one
// ending on byte 12 leaves untagged. o_run_last marks the final output byte
// caused by an input byte.
// tag_control lives at byte address 0 and should be written only while no
// frame is in flight.
// ----------------------------------------------------------------------------
module vlan_tag_insert_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input byte stream
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_frame_byte,
    input  logic                            i_frame_end,
    // output byte stream
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_out_end,
    output logic                            o_run_last,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [vti_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [vti_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [vti_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import vti_pkg::*;

    logic [TCI_W-1:0] r_tci;
    logic             tci_sel;
    logic             q_full;
    logic             q_push;
    t_q_entry         q_push_entry;
    logic             q_pop;
    logic             q_valid;
    t_q_entry         q_head;

    // Register 0 decodes on address bit 2 clear; bit 2 set is unmapped.
    assign tci_sel = !paddr[2];
    assign pready  = 1'b1;
    assign prdata  = tci_sel ? {{(APB_DATA_W-TCI_W){1'b0}}, r_tci} : '0;

    // Capture the TCI at the access phase of a write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tci <= '0;
        end else if (psel && penable && pwrite && tci_sel) begin
            r_tci <= pwdata[TCI_W-1:0];
        end
    end

    // Front end: position tracking, hold of byte 12, TPID decision.
    vti_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .o_in_stall   (o_in_stall),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_push_entry (q_push_entry)
    );

    // Decouple the two ends so a tag burst does not stall the link at once.
    vti_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_entry (q_push_entry),
        .o_full       (q_full),
        .i_pop        (q_pop),
        .o_valid      (q_valid),
        .o_head       (q_head)
    );

    // Back end: one output byte per cycle while the output is not stalled, tags expanded in place.
    vti_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tci       (r_tci),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_end   (o_out_end),
        .o_run_last  (o_run_last),
        .i_out_stall (i_out_stall)
    );

endmodule
